>>> design/lcgbr_pkg.sv
// ----------------------------------------------------------------------------
// lcgbr_pkg: shared types and constants for the LCG bounded random source
// Holds data widths, generator constants, request codes, result modes,
// controller states and the command/status structs between ctrl and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcgbr_pkg;

    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int TYPE_W     = 3;
    localparam int PROB_W     = 54;
    localparam int UNIT_W     = 53;
    localparam int UNIT_SHIFT = 11;
    localparam int DIV_CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [DATA_W-1:0] LCG_INC = 64'd1;

    // Request codes; code 7 is unused and handled by default arms
    localparam logic [TYPE_W-1:0] REQ_SEED   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_RAW    = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_UNIT   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_BELOW  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_RANGE  = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_DICE   = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_CHANCE = 3'd6;

    typedef enum logic [2:0] {
        RM_IMM,
        RM_RAW,
        RM_UNIT,
        RM_CHANCE,
        RM_BELOW
    } res_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ROUTE,
        S_STEP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CHECK,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic step_go;
        logic div_start;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        res_mode_t mode;
        logic      step_last;
        logic      div_done;
        logic      draw_ok;
    } dp_status_t;

endpackage

>>> design/lcgbr_req_if.sv
// ----------------------------------------------------------------------------
// lcgbr_req_if: request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcgbr_req_if
    import lcgbr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] value_a;
    logic signed [DATA_W-1:0] value_b;
    logic [PROB_W-1:0]        chance_probability;

    modport source (
        output valid, req_type, value_a, value_b, chance_probability,
        input  ready
    );

    modport sink (
        input  valid, req_type, value_a, value_b, chance_probability,
        output ready
    );
endinterface

>>> design/lcgbr_rsp_if.sv
// ----------------------------------------------------------------------------
// lcgbr_rsp_if: result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcgbr_rsp_if
    import lcgbr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;

    modport source (
        output valid, result_value,
        input  ready
    );

    modport sink (
        input  valid, result_value,
        output ready
    );
endinterface

>>> design/lcgbr_div.sv
// ----------------------------------------------------------------------------
// lcgbr_div: serial remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcgbr_div
    import lcgbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] remainder
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvd_reg, dvd_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial value when subtracting would borrow
            rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> design/lcgbr_dp.sv
// ----------------------------------------------------------------------------
// lcgbr_dp: datapath of the LCG bounded random source
// Generator state, four-phase 32x32 step multiplier, bound setup, two
// remainder units (rejection limit and draw) and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcgbr_dp
    import lcgbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [TYPE_W-1:0] req_type,
    input  logic [DATA_W-1:0] value_a,
    input  logic [DATA_W-1:0] value_b,
    input  logic [PROB_W-1:0] chance_probability,
    output logic [DATA_W-1:0] result_value
);

    logic [TYPE_W-1:0] type_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [PROB_W-1:0] p_reg;

    logic [DATA_W-1:0] lcg_state_reg, lcg_state_next;
    res_mode_t         mode_reg, mode_next;
    logic [DATA_W-1:0] imm_reg, imm_next;
    logic [DATA_W-1:0] bound_reg, bound_next;
    logic [DATA_W-1:0] base_reg, base_next;
    logic [1:0]        phase_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic              a_gt_b;
    logic [DATA_W-1:0] lo_val;
    logic [DATA_W-1:0] hi_val;
    logic [DATA_W-1:0] span;
    logic              lim_done;
    logic              draw_done;
    logic [DATA_W-1:0] lim_rem;
    logic [DATA_W-1:0] draw_rem;
    logic [UNIT_W-1:0] unit_val;

    // capture the request transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req_type;
            a_reg    <= value_a;
            b_reg    <= value_b;
            p_reg    <= chance_probability;
        end
    end

    // request decode: result mode, immediate answer, bound and offset
    assign a_gt_b = $signed(a_reg) > $signed(b_reg);
    assign lo_val = a_gt_b ? b_reg : a_reg;
    assign hi_val = a_gt_b ? a_reg : b_reg;
    assign span   = hi_val - lo_val + LCG_INC;

    always_comb
    begin
        mode_next  = RM_IMM;
        imm_next   = '0;
        bound_next = b_reg;
        base_next  = '0;
        case (type_reg)
            REQ_SEED:
            begin
                mode_next = RM_IMM;
            end
            REQ_RAW:
            begin
                mode_next = RM_RAW;
            end
            REQ_UNIT:
            begin
                mode_next = RM_UNIT;
            end
            REQ_BELOW:
            begin
                mode_next = (b_reg == '0 || b_reg[DATA_W-1]) ? RM_IMM : RM_BELOW;
            end
            REQ_RANGE:
            begin
                mode_next  = (span == '0) ? RM_RAW : RM_BELOW;
                bound_next = span;
                base_next  = lo_val;
            end
            REQ_DICE:
            begin
                mode_next  = (a_reg == '0 || a_reg[DATA_W-1]) ? RM_IMM : RM_BELOW;
                imm_next   = LCG_INC;
                bound_next = a_reg;
                base_next  = LCG_INC;
            end
            REQ_CHANCE:
            begin
                if (p_reg == '0)
                begin
                    mode_next = RM_IMM;
                end
                else if (p_reg[PROB_W-1])
                begin
                    mode_next = RM_IMM;
                    imm_next  = LCG_INC;
                end
                else
                begin
                    mode_next = RM_CHANCE;
                end
            end
            default:
            begin
                mode_next = RM_IMM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RM_IMM;
        end
        else if (cmd.prep)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            imm_reg   <= imm_next;
            bound_reg <= bound_next;
            base_reg  <= base_next;
        end
    end

    // step: state * MUL + 1 from three 32x32 partial products
    //   phase 0: lo*lo, phase 1: hi*lo, phase 2: lo*hi, phase 3: write state
    always_comb
    begin
        case (phase_reg)
            2'd1:
            begin
                mul_a = lcg_state_reg[DATA_W-1:HALF_W];
                mul_b = LCG_MUL[HALF_W-1:0];
            end
            2'd2:
            begin
                mul_a = lcg_state_reg[HALF_W-1:0];
                mul_b = LCG_MUL[DATA_W-1:HALF_W];
            end
            default:
            begin
                mul_a = lcg_state_reg[HALF_W-1:0];
                mul_b = LCG_MUL[HALF_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (phase_reg)
            2'd1:
            begin
                acc_next = prod_reg + LCG_INC;
            end
            2'd2:
            begin
                acc_next = {acc_reg[DATA_W-1:HALF_W] + prod_reg[HALF_W-1:0],
                            acc_reg[HALF_W-1:0]};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        lcg_state_next = lcg_state_reg;
        if (cmd.prep && type_reg == REQ_SEED)
        begin
            lcg_state_next = a_reg;
        end
        else if (cmd.step_go && phase_reg == 2'd3)
        begin
            lcg_state_next = {acc_reg[DATA_W-1:HALF_W] + prod_reg[HALF_W-1:0],
                              acc_reg[HALF_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_state_reg <= '0;
            phase_reg     <= 2'd0;
        end
        else
        begin
            lcg_state_reg <= lcg_state_next;
            if (cmd.step_go)
            begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_go)
        begin
            prod_reg <= mul_a * mul_b;
            acc_reg  <= acc_next;
        end
    end

    // rejection limit (2^64 mod bound) and draw remainder run side by side
    lcgbr_div u_lim_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  ('0 - bound_reg),
        .divisor   (bound_reg),
        .done      (lim_done),
        .remainder (lim_rem)
    );

    lcgbr_div u_draw_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (lcg_state_reg),
        .divisor   (bound_reg),
        .done      (draw_done),
        .remainder (draw_rem)
    );

    // result selection
    assign unit_val = lcg_state_reg[DATA_W-1:UNIT_SHIFT];

    always_comb
    begin
        case (mode_reg)
            RM_RAW:    result_next = lcg_state_reg;
            RM_UNIT:   result_next = {{(DATA_W-UNIT_W){1'b0}}, unit_val};
            RM_CHANCE: result_next = {{(DATA_W-1){1'b0}}, unit_val < p_reg[UNIT_W-1:0]};
            RM_BELOW:  result_next = base_reg + draw_rem;
            default:   result_next = imm_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result_value     = result_reg;
    assign status.mode      = mode_reg;
    assign status.step_last = cmd.step_go && phase_reg == 2'd3;
    assign status.div_done  = lim_done;
    assign status.draw_ok   = lcg_state_reg >= lim_rem;

    assert property (@(posedge clk) disable iff (!rst_n) lim_done == draw_done)
        else $error("remainder units out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> $stable(lcg_state_reg))
        else $error("state moved while remainder units run");

endmodule

>>> design/lcgbr_ctrl.sv
// ----------------------------------------------------------------------------
// lcgbr_ctrl: controller of the LCG bounded random source
// Sequences decode, step, remainder and rejection check; owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcgbr_ctrl
    import lcgbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                state_next = (status.mode == RM_IMM) ? S_FINISH : S_STEP;
            end
            S_STEP:
            begin
                if (status.step_last)
                begin
                    state_next = (status.mode == RM_BELOW) ? S_DIV_GO : S_FINISH;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // reject draws below the limit and step again
                state_next = status.draw_ok ? S_FINISH : S_STEP;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.capture     = 1'b0;
        cmd.prep        = 1'b0;
        cmd.step_go     = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
            end
            S_STEP:
            begin
                cmd.step_go = 1'b1;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_PREP)
        else $error("accepted request did not start decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("loaded result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.step_last |-> state_reg == S_STEP)
        else $error("step phase out of line with controller");

endmodule

>>> design/lcg_bounded_random_source.sv
// Immediate answers (seed, non-positive bounds, chance at 0 or 1) pass through decode,
// route and finish; raw, unit and chance draws add the four-phase multiply.
// Bounded draws (int below, range, dice) then run the serial remainder units and the
// rejection check, and repeat the step and remainder units for each rejected draw (rare).
// Throughput: one transaction in flight; the next is taken once the result is loaded.
// Reset (async, active low) clears the generator state to zero and empties the output.
// ----------------------------------------------------------------------------
// lcg_bounded_random_source: 64-bit LCG random source with bounded draws
// Top level: joins the request/result channels to the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_bounded_random_source
    import lcgbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lcgbr_req_if.sink   req,
    lcgbr_rsp_if.source rsp
);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [DATA_W-1:0] result_value;

    // Controller: walks each transaction through decode, the multi-phase step,
    // the remainder units and the rejection check, and holds the result valid
    // until the sink takes it. A new request is taken in idle even while a
    // previous result still waits; finishing then waits for the output slot.
    lcgbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: generator state, shared 32x32 multiplier, bound decode, the
    // two remainder units and the output register.
    lcgbr_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req_type           (req.req_type),
        .value_a            (req.value_a),
        .value_b            (req.value_b),
        .chance_probability (req.chance_probability),
        .result_value       (result_value)
    );

    // Drive the signed result field from the output register
    assign rsp.result_value = result_value;

endmodule

>>> test/lcg_bounded_random_source_test.sv
// ----------------------------------------------------------------------------
// lcg_bounded_random_source_test: self-checking bench for the LCG random source
// Sends directed and random requests of every kind over the request channel,
// predicts each answer with a local copy of the 64-bit generator, and checks
// every result transaction in order while both channels idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_bounded_random_source_test;
    import lcgbr_pkg::*;

    // Request code 7 has no name in the package; the block answers it with 0.
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;

    // Generator step and fixed-point constants, kept independent of the RTL.
    localparam logic [DATA_W-1:0] STEP_MUL = 64'd6364136223846793005;
    localparam logic [DATA_W-1:0] STEP_INC = 64'd1;
    localparam logic [PROB_W-1:0] PROB_ONE = 54'h20_0000_0000_0000;
    localparam logic [DATA_W-1:0] INT_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Run control. Bounded draws are the slowest kind, with rare rejections on
    // top; sender gaps and receiver stalls slow the run further.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEM_TARGET   = 1100;
    localparam int DRAIN_EVERY   = 250;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [PROB_W-1:0] prob;
    } draw_req_t;

    logic clk = 1'b0;
    logic rst_n;

    lcgbr_req_if req_ch ();
    lcgbr_rsp_if rsp_ch ();

    lcg_bounded_random_source uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Predictor state: the generator word as the block should hold it.
    logic [DATA_W-1:0] gen_state;
    // Answers still owed by the block, oldest first.
    logic [DATA_W-1:0] expected_draws[$];
    logic [DATA_W-1:0] oldest_draw;

    int mismatch_count = 0;
    int result_index   = 0;
    int cycle_count    = 0;
    int burst_left     = 1;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Advance the generator one step and return the new word.
    function automatic logic [DATA_W-1:0] step_generator();
        gen_state = gen_state * STEP_MUL + STEP_INC;
        return gen_state;
    endfunction

    // Top 53 bits of a fresh step, read as a fraction of 2^53.
    function automatic logic [DATA_W-1:0] unit_fraction();
        return step_generator() >> UNIT_SHIFT;
    endfunction

    // Unbiased draw in [0, bound): drop steps under (2^64 mod bound), retry.
    function automatic logic [DATA_W-1:0] draw_below(input logic [DATA_W-1:0] bound);
        logic [DATA_W-1:0] floor_reject;
        logic [DATA_W-1:0] x;
        floor_reject = (64'd0 - bound) % bound;
        x = step_generator();
        while (x < floor_reject)
            x = step_generator();
        return x % bound;
    endfunction

    // Work out the one answer a request earns, updating the generator state.
    function automatic logic [DATA_W-1:0] predict_draw(input draw_req_t r);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] res;
        res = '0;
        case (r.kind)
            REQ_SEED: begin
                gen_state = r.a;
            end
            REQ_RAW:   res = step_generator();
            REQ_UNIT:  res = unit_fraction();
            REQ_BELOW: begin
                // Zero or negative max: answer 0, no step.
                if (r.b != 0 && !r.b[DATA_W-1])
                    res = draw_below(r.b);
            end
            REQ_RANGE: begin
                lo = r.a;
                hi = r.b;
                if ($signed(lo) > $signed(hi))
                begin
                    lo = r.b;
                    hi = r.a;
                end
                span = hi - lo + 64'd1;
                // A span that wraps to zero covers all 2^64 values.
                if (span == 0)
                    res = step_generator();
                else
                    res = lo + draw_below(span);
            end
            REQ_DICE: begin
                if (r.a == 0 || r.a[DATA_W-1])
                    res = 64'd1;
                else
                    res = 64'd1 + draw_below(r.a);
            end
            REQ_CHANCE: begin
                // Clamp at never and always without stepping.
                if (r.prob == 0)
                    res = 64'd0;
                else if (r.prob >= PROB_ONE)
                    res = 64'd1;
                else
                    res = (unit_fraction() < {10'd0, r.prob}) ? 64'd1 : 64'd0;
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic draw_req_t make_req(input logic [TYPE_W-1:0] kind,
                                           input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b,
                                           input logic [PROB_W-1:0] prob);
        draw_req_t r;
        r.kind = kind;
        r.a    = a;
        r.b    = b;
        r.prob = prob;
        return r;
    endfunction

    // Drive one request, hold it until the transaction completes, then log the
    // expected answer. Call only right after a rising edge. Valid stays high
    // into the next request inside a burst; between bursts, it drops for a random gap, sometimes none.
    task automatic send_request(input draw_req_t r);
        int gap;
        req_ch.valid              <= 1'b1;
        req_ch.req_type           <= r.kind;
        req_ch.value_a            <= r.a;
        req_ch.value_b            <= r.b;
        req_ch.chance_probability <= r.prob;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_draws.push_back(predict_draw(r));

        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Mostly short bursts, now and then a long one with no idling.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold off the sender until every owed answer has come back. The wait loop
    // checks only once the clock has risen, so the drop of valid never meets the next drive.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_draws.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------

    // Operand mix: full random words, small magnitudes, the signed extremes
    // and powers of two, so both bound checks and rejection get exercised.
    function automatic logic [DATA_W-1:0] random_operand();
        logic [DATA_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1: return w;
            2:    return {32'd0, $urandom_range(1, 1000)};
            3:    return 64'd0 - {32'd0, $urandom_range(1, 1000)};
            4: begin
                case ($urandom_range(0, 3))
                    0:       return INT_MIN + {32'd0, $urandom_range(0, 3)};
                    1:       return INT_MAX - {32'd0, $urandom_range(0, 3)};
                    2:       return 64'd0;
                    default: return 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            5:       return (64'd1 << $urandom_range(0, 63)) + {32'd0, $urandom_range(0, 2)}
                            - 64'd1;
            6:       return w >> 1;
            default: return {32'd0, $urandom};
        endcase
    endfunction

    // Probability mix: raw 54-bit codes (half of them at or above 2^53),
    // in-range fractions, the clamp points and values next to them.
    function automatic logic [PROB_W-1:0] random_probability();
        logic [DATA_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:    return w[PROB_W-1:0];
            1, 2: return {1'b0, w[UNIT_W-1:0]};
            3: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return PROB_ONE;
                    2:       return PROB_ONE - 54'd1;
                    default: return 54'd1;
                endcase
            end
            4:       return {22'd0, $urandom_range(1, 1000)};
            default: return ($urandom_range(0, 1) != 0) ? PROB_ONE + {22'd0, $urandom_range(0, 64)}
                                                         : PROB_ONE - {22'd0, $urandom_range(1, 64)};
        endcase
    endfunction

    function automatic draw_req_t random_request();
        draw_req_t r;
        int roll;
        roll   = $urandom_range(0, 99);
        r.a    = random_operand();
        r.b    = random_operand();
        r.prob = random_probability();
        if (roll < 5)
            r.kind = REQ_SEED;
        else if (roll < 8)
            r.kind = REQ_UNUSED;
        else
        begin
            case (roll % 6)
                0:       r.kind = REQ_RAW;
                1:       r.kind = REQ_UNIT;
                2:       r.kind = REQ_BELOW;
                3:       r.kind = REQ_RANGE;
                4:       r.kind = REQ_DICE;
                default: r.kind = REQ_CHANCE;
            endcase
        end
        // Keep many ranges narrow and near each other, either order.
        if (r.kind == REQ_RANGE && $urandom_range(0, 4) < 2)
            r.b = r.a + {32'd0, $urandom_range(0, 200)} - 64'd100;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Raw and unit from the reset state, seeds at the signed extremes, and the
    // unused code, which must answer 0 without stepping.
    task automatic test_seed_raw_unit();
        send_request(make_req(REQ_RAW,    '0,      '0, '0));
        send_request(make_req(REQ_UNIT,   '0,      '0, '0));
        send_request(make_req(REQ_SEED,   INT_MIN, '0, '0));
        send_request(make_req(REQ_RAW,    '0,      '0, '0));
        send_request(make_req(REQ_SEED,   INT_MAX, 64'hFFFF_FFFF_FFFF_FFFF, '1));
        send_request(make_req(REQ_UNUSED, INT_MAX, INT_MIN, PROB_ONE));
        send_request(make_req(REQ_UNIT,   '0,      '0, '0));
    endtask

    // Zero and negative max answer 0 with no step; max of one steps and
    // answers 0; the largest max has a rejection floor of two.
    task automatic test_int_below();
        send_request(make_req(REQ_BELOW, '0, 64'd0,   '0));
        send_request(make_req(REQ_BELOW, '0, INT_MIN, '0));
        send_request(make_req(REQ_BELOW, '0, 64'd1,   '0));
        send_request(make_req(REQ_BELOW, '0, INT_MAX, '0));
        send_request(make_req(REQ_BELOW, '0, 64'd10,  '0));
    endtask

    // Equal bounds, inverted bounds, and the full 2^64 span in both orders.
    task automatic test_range();
        send_request(make_req(REQ_RANGE, 64'd0 - 64'd3,   64'd0 - 64'd3,   '0));
        send_request(make_req(REQ_RANGE, 64'd100,         64'd0 - 64'd100, '0));
        send_request(make_req(REQ_RANGE, INT_MIN,         INT_MAX,         '0));
        send_request(make_req(REQ_RANGE, INT_MAX,         INT_MIN,         '0));
    endtask

    // Zero and negative sides answer 1 with no step; sides of 6 and INT_MAX draw.
    task automatic test_dice();
        send_request(make_req(REQ_DICE, 64'd0,                   '0, '0));
        send_request(make_req(REQ_DICE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0));
        send_request(make_req(REQ_DICE, 64'd6,                   '0, '0));
        send_request(make_req(REQ_DICE, INT_MAX,                 '0, '0));
    endtask

    // Never, certain, codes above certain, and the two in-range extremes.
    task automatic test_chance();
        send_request(make_req(REQ_CHANCE, '0, '0, '0));
        send_request(make_req(REQ_CHANCE, '0, '0, PROB_ONE));
        send_request(make_req(REQ_CHANCE, '0, '0, '1));
        send_request(make_req(REQ_CHANCE, '0, '0, 54'd1));
        send_request(make_req(REQ_CHANCE, '0, '0, PROB_ONE - 54'd1));
    endtask

    // Random mix of all kinds; drain fully every so often. Unused-code
    // requests go out but do not advance the item count.
    task automatic test_random_traffic();
        draw_req_t r;
        int counted;
        counted = 0;
        while (counted < ITEM_TARGET)
        begin
            r = random_request();
            send_request(r);
            if (r.kind != REQ_UNUSED)
            begin
                counted++;
                if (counted % DRAIN_EVERY == 0)
                    wait_for_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] result %0d %s: expected %h, got %h",
                     $realtime, result_index, what, want, got);
    endtask

    // Receiver stall pattern: runs of always-ready, coin-flip ready, mostly
    // ready, and long stalls, each run of random length.
    initial begin : result_stall_pattern
        int mode;
        int run;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(8, 48);
            for (int i = 0; i < run; i++)
            begin
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                    2:       rsp_ch.ready <= (i % 5 != 0);
                    default: rsp_ch.ready <= (i % 8 == 7);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each result transaction with the oldest owed answer.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_draws.size() == 0)
                note_mismatch("arrived with nothing owed", '0, rsp_ch.result_value);
            else
            begin
                oldest_draw = expected_draws.pop_front();
                if (rsp_ch.result_value !== oldest_draw)
                    note_mismatch("result_value", oldest_draw, rsp_ch.result_value);
            end
            result_index++;
        end
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d results owed",
                     $realtime, cycle_count, expected_draws.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n                     <= 1'b0;
        req_ch.valid              <= 1'b0;
        req_ch.req_type           <= REQ_SEED;
        req_ch.value_a            <= '0;
        req_ch.value_b            <= '0;
        req_ch.chance_probability <= '0;
        gen_state = '0;

        // Hold reset, then release it; the generator word comes up zero.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_seed_raw_unit();
        test_int_below();
        test_range();
        test_dice();
        test_chance();
        wait_for_drain();
        test_random_traffic();
        wait_for_drain();

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_draws.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/lcgbr_pkg.sv
design/lcgbr_req_if.sv
design/lcgbr_rsp_if.sv
design/lcgbr_div.sv
design/lcgbr_dp.sv
design/lcgbr_ctrl.sv
design/lcg_bounded_random_source.sv
test/lcg_bounded_random_source_test.sv
